// ===== hdl/mqfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mqfb_pkg
// Shared constants, codes and types of the multi-queue burst FIFO bank.
// ----------------------------------------------------------------------------
package mqfb_pkg;

    localparam int QUEUES      = 8;
    localparam int QUEUE_DEPTH = 64;   // power of two
    localparam int VALUE_BITS  = 32;

    localparam int QID_W   = 3;
    localparam int FUNC_W  = 2;
    localparam int REP_W   = 7;
    localparam int CFG_W   = 4;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = QID_W + PTR_W;
    localparam int ENTRIES = QUEUES * QUEUE_DEPTH;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] QUEUES_RESET = CFG_W'(QUEUES);

    typedef enum logic [0:0] {
        REG_QUEUES_IN_USE = 1'b0
    } t_reg;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_PUSH  = 2'd1,
        FUNC_POP   = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PUSH,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [VALUE_BITS-1:0] wr_data;
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
    } t_mem_req;

endpackage

// ===== hdl/mqfb_if.sv =====
// ----------------------------------------------------------------------------
// mqfb_in_if / mqfb_out_if
// Valid/ready channels for command requests and result requests.
// ----------------------------------------------------------------------------
interface mqfb_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [mqfb_pkg::FUNC_W-1:0]           func;
    logic [mqfb_pkg::QID_W-1:0]            queue_id;
    logic signed [mqfb_pkg::VALUE_BITS-1:0] value;
    logic [mqfb_pkg::REP_W-1:0]            repeat_req;

    modport source (output valid, func, queue_id, value, repeat_req, input ready);
    modport sink   (input valid, func, queue_id, value, repeat_req, output ready);
endinterface

interface mqfb_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  is_null;
    logic signed [mqfb_pkg::VALUE_BITS-1:0] front_value;
    logic                                  overflow;

    modport source (output valid, is_null, front_value, overflow, input ready);
    modport sink   (input valid, is_null, front_value, overflow, output ready);
endinterface

// ===== hdl/mqfb_store.sv =====
// ----------------------------------------------------------------------------
// mqfb_store
// Entry memory of all queues: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mqfb_store (
    input  logic                            i_clk,
    input  mqfb_pkg::t_mem_req              i_mem_req,
    output logic [mqfb_pkg::VALUE_BITS-1:0] o_rd_data
);
    import mqfb_pkg::*;

    logic [VALUE_BITS-1:0] r_mem [ENTRIES];
    logic [VALUE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_mem_req.wr_en) begin
            r_mem[i_mem_req.wr_addr] <= i_mem_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_req.rd_en) begin
            r_rd_data <= r_mem[i_mem_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/mqfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mqfb_ctrl
// Command sequencer: queue pointers, burst write loop and result register.
// ----------------------------------------------------------------------------
module mqfb_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [mqfb_pkg::CFG_W-1:0]      i_queues_in_use,
    mqfb_in_if.sink                         i_req,
    mqfb_out_if.source                      o_rsp,
    output mqfb_pkg::t_mem_req              o_mem_req,
    input  logic [mqfb_pkg::VALUE_BITS-1:0] i_rd_data
);
    import mqfb_pkg::*;

    t_state                r_state, n_state;
    logic [FUNC_W-1:0]     r_func, n_func;
    logic [QID_W-1:0]      r_qid, n_qid;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [REP_W-1:0]      r_reps, n_reps;
    logic [PTR_W-1:0]      r_pos, n_pos;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_null, n_null;
    logic                  r_ovf, n_ovf;
    logic                  r_pop, n_pop;
    logic [PTR_W-1:0]      r_head [QUEUES];
    logic [PTR_W-1:0]      n_head [QUEUES];
    logic [CNT_W-1:0]      r_fill [QUEUES];
    logic [CNT_W-1:0]      n_fill [QUEUES];
    logic                  r_out_vld, n_out_vld;
    logic                  r_out_null, n_out_null;
    logic                  r_out_ovf, n_out_ovf;
    logic [VALUE_BITS-1:0] r_out_front, n_out_front;

    logic                  q_active;
    logic [PTR_W-1:0]      cur_head;
    logic [CNT_W-1:0]      cur_fill;
    logic [CNT_W-1:0]      room;
    logic [CNT_W-1:0]      reps_ext;
    logic [CNT_W-1:0]      push_take;
    logic [CNT_W-1:0]      pop_take;
    logic [CNT_W-1:0]      tail_sum;
    logic [CNT_W-1:0]      head_sum;

    assign cur_head  = r_head[r_qid];
    assign cur_fill  = r_fill[r_qid];
    assign q_active  = (CFG_W'(r_qid) < i_queues_in_use) && (CFG_W'(r_qid) < QUEUES_RESET);
    assign room      = CNT_W'(QUEUE_DEPTH) - cur_fill;
    assign reps_ext  = CNT_W'(r_reps);
    assign push_take = (reps_ext < room) ? reps_ext : room;
    assign pop_take  = (reps_ext < cur_fill) ? reps_ext : cur_fill;
    assign tail_sum  = CNT_W'(cur_head) + cur_fill;
    assign head_sum  = CNT_W'(cur_head) + pop_take;

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.is_null     = r_out_null;
    assign o_rsp.overflow    = r_out_ovf;
    assign o_rsp.front_value = r_out_front;

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_qid       = r_qid;
        n_value     = r_value;
        n_reps      = r_reps;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_null      = r_null;
        n_ovf       = r_ovf;
        n_pop       = r_pop;
        n_head      = r_head;
        n_fill      = r_fill;
        n_out_vld   = r_out_vld;
        n_out_null  = r_out_null;
        n_out_ovf   = r_out_ovf;
        n_out_front = r_out_front;
        o_mem_req   = '0;

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_qid   = i_req.queue_id;
                    n_value = i_req.value;
                    n_reps  = i_req.repeat_req;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                n_null  = 1'b0;
                n_ovf   = 1'b0;
                n_pop   = 1'b0;
                case (r_func)
                    FUNC_CLEAR: begin
                        for (int q = 0; q < QUEUES; q++) begin
                            n_head[q] = '0;
                            n_fill[q] = '0;
                        end
                    end
                    FUNC_PUSH: begin
                        if (q_active) begin
                            n_fill[r_qid] = cur_fill + push_take;
                            n_pos         = tail_sum[PTR_W-1:0];
                            n_cnt         = push_take;
                            n_ovf         = (push_take < reps_ext);
                            n_state       = ST_PUSH;
                        end
                    end
                    FUNC_POP: begin
                        if (q_active) begin
                            n_state = ST_RESULT;
                            if (cur_fill == '0) begin
                                n_null = 1'b1;
                            end else begin
                                n_pop             = 1'b1;
                                o_mem_req.rd_en   = 1'b1;
                                o_mem_req.rd_addr = {r_qid, cur_head};
                                n_head[r_qid]     = head_sum[PTR_W-1:0];
                                n_fill[r_qid]     = cur_fill - pop_take;
                            end
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_PUSH: begin
                if (r_cnt == '0) begin
                    n_state = r_ovf ? ST_RESULT : ST_IDLE;
                end else begin
                    o_mem_req.wr_en   = 1'b1;
                    o_mem_req.wr_addr = {r_qid, r_pos};
                    o_mem_req.wr_data = r_value;
                    n_pos             = r_pos + PTR_W'(1);
                    n_cnt             = r_cnt - CNT_W'(1);
                end
            end
            ST_RESULT: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld   = 1'b1;
                    n_out_null  = r_null;
                    n_out_ovf   = r_ovf;
                    n_out_front = r_pop ? i_rd_data : '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            for (int q = 0; q < QUEUES; q++) begin
                r_head[q] <= '0;
                r_fill[q] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_head    <= n_head;
            r_fill    <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_qid       <= n_qid;
        r_value     <= n_value;
        r_reps      <= n_reps;
        r_pos       <= n_pos;
        r_cnt       <= n_cnt;
        r_null      <= n_null;
        r_ovf       <= n_ovf;
        r_pop       <= n_pop;
        r_out_null  <= n_out_null;
        r_out_ovf   <= n_out_ovf;
        r_out_front <= n_out_front;
    end

endmodule

// ===== hdl/multi_queue_burst_fifo_bank.sv =====
// Sequence: a clear runs in the execute state; a pop reads the entry there and then gives
// a result; a push writes its copies in the burst state and ends in an overflow result when copies are dropped.
// Throughput: one request at a time; the burst loop writes one entry per cycle through
// the single memory write port.
// A result waits in an output register while the next request is taken.
// Reset (synchronous, active low) empties all queues and sets queues_in_use to 8.
// ----------------------------------------------------------------------------
// multi_queue_burst_fifo_bank
// Bank of independent FIFO queues with clear, burst push and multi-entry pop.
// ----------------------------------------------------------------------------
module multi_queue_burst_fifo_bank (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mqfb_in_if.sink                         i_req,
    mqfb_out_if.source                      o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mqfb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mqfb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mqfb_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mqfb_pkg::*;

    logic [CFG_W-1:0]      r_queues_in_use;
    t_mem_req              mem_req;
    logic [VALUE_BITS-1:0] rd_data;
    logic                  reg_hit;

    assign reg_hit = (paddr[2] == REG_QUEUES_IN_USE);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? APB_DATA_W'(r_queues_in_use) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queues_in_use <= QUEUES_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_queues_in_use <= pwdata[CFG_W-1:0];
        end
    end

    mqfb_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_queues_in_use (r_queues_in_use),
        .i_req           (i_req),
        .o_rsp           (o_rsp),
        .o_mem_req       (mem_req),
        .i_rd_data       (rd_data)
    );

    mqfb_store u_store (
        .i_clk     (i_clk),
        .i_mem_req (mem_req),
        .o_rd_data (rd_data)
    );

endmodule

// ===== hdl/mqfb_checker.sv =====
// ----------------------------------------------------------------------------
// mqfb_checker
// Port-level checks of the FIFO bank, bound to the top level.
// ----------------------------------------------------------------------------
module mqfb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic                            i_is_null,
    input logic                            i_overflow,
    input logic [mqfb_pkg::VALUE_BITS-1:0] i_front_value
);
    import mqfb_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_is_null && i_overflow))
        else $error("empty and overflow flags both set");

    a_flag_zero_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_is_null || i_overflow) |-> (i_front_value == '0))
        else $error("flagged result carries a front value");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one is in progress");

endmodule

bind multi_queue_burst_fifo_bank mqfb_checker u_mqfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_is_null     (o_rsp.is_null),
    .i_overflow    (o_rsp.overflow),
    .i_front_value (o_rsp.front_value)
);

// ===== bench/multi_queue_burst_fifo_bank_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_burst_fifo_bank_checker
// Watches the command and result channels and the register port of the FIFO
// bank, keeps a shadow copy of every queue, predicts the result of each
// accepted command and compares it field by field with the results that
// come out in order.
// ----------------------------------------------------------------------------
module multi_queue_burst_fifo_bank_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mqfb_in_if                              i_req,
    mqfb_out_if                             i_rsp,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [mqfb_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [mqfb_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_result_count,
    output int                              o_overflow_count,
    output int                              o_null_count
);
    import mqfb_pkg::*;

    typedef struct packed {
        logic                         is_null;
        logic signed [VALUE_BITS-1:0] front_value;
        logic                         overflow;
    } t_result;

    t_result                      expected_results[$];
    logic signed [VALUE_BITS-1:0] queue_mem [QUEUES][QUEUE_DEPTH];
    logic [PTR_W-1:0]             head_idx [QUEUES];
    int                           fill_cnt [QUEUES];
    logic [CFG_W-1:0]             queues_active;
    int                           mismatches;
    int                           results_seen;
    int                           overflows;
    int                           nulls;

    task automatic empty_queues();
        for (int q = 0; q < QUEUES; q++) begin
            head_idx[q] = '0;
            fill_cnt[q] = 0;
        end
    endtask

    task automatic predict_command(
        input logic [FUNC_W-1:0]            func,
        input logic [QID_W-1:0]             qid,
        input logic signed [VALUE_BITS-1:0] value,
        input logic [REP_W-1:0]             reps
    );
        int               active;
        int               want;
        int               fill;
        int               take;
        logic [PTR_W-1:0] pos;
        t_result          res;
        active = (int'(queues_active) < QUEUES) ? int'(queues_active) : QUEUES;
        want = int'(reps);
        fill = fill_cnt[qid];
        res = '0;
        case (func)
            FUNC_CLEAR: begin
                empty_queues();
            end
            FUNC_PUSH: begin
                if (int'(qid) < active) begin
                    take = (want < QUEUE_DEPTH - fill) ? want : QUEUE_DEPTH - fill;
                    pos = head_idx[qid] + PTR_W'(fill);
                    for (int i = 0; i < take; i++) begin
                        queue_mem[qid][pos] = value;
                        pos = pos + 1'b1;
                    end
                    fill_cnt[qid] = fill + take;
                    if (take < want) begin
                        res.overflow = 1'b1;
                        expected_results.insert(expected_results.size(), res);
                    end
                end
            end
            FUNC_POP: begin
                if (int'(qid) < active) begin
                    if (fill == 0) begin
                        res.is_null = 1'b1;
                    end else begin
                        res.front_value = queue_mem[qid][head_idx[qid]];
                        take = (want < fill) ? want : fill;
                        head_idx[qid] = head_idx[qid] + PTR_W'(take);
                        fill_cnt[qid] = fill - take;
                    end
                    expected_results.insert(expected_results.size(), res);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            empty_queues();
            expected_results.delete();
            queues_active = QUEUES_RESET;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with no request pending: %s %0b %s %0d %s %0b",
                           "is_null", i_rsp.is_null, "front_value", i_rsp.front_value,
                           "overflow", i_rsp.overflow);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.overflow) overflows++;
                    if (want.is_null) nulls++;
                    if (i_rsp.is_null !== want.is_null) begin
                        $error("is_null: expected %0b, got %0b",
                               want.is_null, i_rsp.is_null);
                        mismatches++;
                    end
                    if (i_rsp.front_value !== want.front_value) begin
                        $error("front_value: expected %0d, got %0d",
                               want.front_value, i_rsp.front_value);
                        mismatches++;
                    end
                    if (i_rsp.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, got %0b",
                               want.overflow, i_rsp.overflow);
                        mismatches++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == APB_ADDR_W'(4 * int'(REG_QUEUES_IN_USE))) begin
                queues_active = i_pwdata[CFG_W-1:0];
            end
            if (i_req.valid && i_req.ready) begin
                predict_command(i_req.func, i_req.queue_id, i_req.value, i_req.repeat_req);
            end
        end
        o_fail_count     <= mismatches;
        o_pending        <= expected_results.size();
        o_result_count   <= results_seen;
        o_overflow_count <= overflows;
        o_null_count     <= nulls;
    end

endmodule

// ===== bench/multi_queue_burst_fifo_bank_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_burst_fifo_bank_tb
// Drives the FIFO bank with a directed set of commands and then with random
// push/pop traffic under several queue counts, with random gaps on both
// channels and one long result stall. The checker predicts and compares;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module multi_queue_burst_fifo_bank_tb;
    import mqfb_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 130;
    localparam int PHASES        = 6;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mqfb_in_if  req_ch ();
    mqfb_out_if rsp_ch ();

    int fail_count;
    int pending;
    int results_checked;
    int overflows_seen;
    int nulls_seen;

    int               pushes;
    int               pops;
    int               clears;
    int               ignored;
    int               reg_writes;
    logic [CFG_W-1:0] queues_setting = QUEUES_RESET;
    bit               sender_gaps = 1'b1;
    bit               receiver_gaps = 1'b1;
    int               hold_requests;
    int               holds_done;
    int               quiet_cycles;

    multi_queue_burst_fifo_bank DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    multi_queue_burst_fifo_bank_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (req_ch),
        .i_rsp            (rsp_ch),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_result_count   (results_checked),
        .o_overflow_count (overflows_seen),
        .o_null_count     (nulls_seen)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int active_queues();
        return (int'(queues_setting) < QUEUES) ? int'(queues_setting) : QUEUES;
    endfunction

    function automatic bit is_ignored(input logic [FUNC_W-1:0] func,
                                      input logic [QID_W-1:0] qid);
        if (func == FUNC_CLEAR) return 1'b0;
        if (func != FUNC_PUSH && func != FUNC_POP) return 1'b1;
        return int'(qid) >= active_queues();
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_requests) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_done++;
            end else if (receiver_gaps && $urandom_range(0, 99) < 25) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap_length() - 1) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_request(
        input logic [FUNC_W-1:0]     func,
        input logic [QID_W-1:0]      qid,
        input logic [VALUE_BITS-1:0] value,
        input logic [REP_W-1:0]      reps
    );
        int gap;
        @(negedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.func       <= func;
        req_ch.queue_id   <= qid;
        req_ch.value      <= value;
        req_ch.repeat_req <= reps;
        do @(posedge i_clk); while (!req_ch.ready);
        if (is_ignored(func, qid)) ignored++;
        else if (func == FUNC_PUSH) pushes++;
        else if (func == FUNC_POP) pops++;
        else clears++;
        if (sender_gaps && $urandom_range(0, 99) < 30) begin
            gap = gap_length();
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_reg idx, input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        queues_setting = data[CFG_W-1:0];
        reg_writes++;
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return {1'b0, {(VALUE_BITS-1){1'b1}}};
            3:       return {1'b1, {(VALUE_BITS-1){1'b0}}};
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [REP_W-1:0] pick_reps(input logic [FUNC_W-1:0] func);
        int r;
        r = $urandom_range(0, 99);
        if (func == FUNC_PUSH) begin
            if (r < 65) return REP_W'($urandom_range(1, 6));
            if (r < 85) return REP_W'($urandom_range(7, 20));
            if (r < 95) return REP_W'($urandom_range(21, QUEUE_DEPTH));
            if (r < 98) return '0;
            return REP_W'($urandom_range(QUEUE_DEPTH + 1, 127));
        end
        if (r < 75) return REP_W'($urandom_range(0, 6));
        if (r < 92) return REP_W'($urandom_range(7, 30));
        return REP_W'($urandom_range(31, 127));
    endfunction

    function automatic logic [QID_W-1:0] pick_queue();
        if (active_queues() > 0 && $urandom_range(0, 9) != 0)
            return QID_W'($urandom_range(0, active_queues() - 1));
        return QID_W'($urandom_range(0, QUEUES - 1));
    endfunction

    task automatic random_requests(input int count);
        int               done;
        int               r;
        logic [FUNC_W-1:0] func;
        logic [QID_W-1:0]  qid;
        done = 0;
        while (done < count) begin
            r = $urandom_range(0, 99);
            if (r < 2) func = FUNC_CLEAR;
            else if (r < 4) func = FUNC_UNUSED;
            else if (r < 52) func = FUNC_PUSH;
            else func = FUNC_POP;
            qid = pick_queue();
            send_request(func, qid, pick_value(), pick_reps(func));
            if (!is_ignored(func, qid)) done++;
        end
    endtask

    task automatic fill_then_stall();
        for (int i = 0; i < 20; i++) begin
            send_request(FUNC_PUSH, pick_queue(), pick_value(),
                         REP_W'($urandom_range(1, 4)));
        end
        hold_requests++;
        for (int i = 0; i < 40; i++) begin
            send_request(FUNC_POP, pick_queue(), '0, REP_W'($urandom_range(0, 2)));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] setting;
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_CLEAR;
        req_ch.queue_id   = '0;
        req_ch.value      = '0;
        req_ch.repeat_req = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(FUNC_POP,  3'd0, '0, 7'd1);
        send_request(FUNC_PUSH, 3'd0, 32'h7FFF_FFFF, 7'd1);
        send_request(FUNC_PUSH, 3'd0, 32'h8000_0000, 7'd2);
        send_request(FUNC_POP,  3'd0, '0, 7'd0);
        send_request(FUNC_POP,  3'd0, '0, 7'd1);
        send_request(FUNC_POP,  3'd0, '0, 7'd127);
        send_request(FUNC_POP,  3'd0, '0, 7'd1);
        send_request(FUNC_PUSH, 3'd7, 32'hFFFF_FFFF, 7'(QUEUE_DEPTH));
        send_request(FUNC_PUSH, 3'd7, 32'h0000_0000, 7'd1);
        send_request(FUNC_PUSH, 3'd7, 32'h0000_0005, 7'd0);
        send_request(FUNC_PUSH, 3'd3, 32'h0000_0001, 7'd0);
        send_request(FUNC_POP,  3'd3, '0, 7'd1);
        send_request(FUNC_PUSH, 3'd6, 32'h1234_5678, 7'd127);
        send_request(FUNC_UNUSED, 3'd1, 32'h5555_5555, 7'd3);
        send_request(FUNC_CLEAR, 3'd0, '0, 7'd0);
        send_request(FUNC_POP,  3'd7, '0, 7'd1);
        send_request(FUNC_PUSH, 3'd2, 32'hA5A5_A5A5, 7'(QUEUE_DEPTH - 1));
        send_request(FUNC_PUSH, 3'd2, 32'h5A5A_5A5A, 7'd2);
        send_request(FUNC_POP,  3'd2, '0, 7'(QUEUE_DEPTH));
        send_request(FUNC_POP,  3'd2, '0, 7'd1);
        send_request(FUNC_PUSH, 3'd0, 32'h0BAD_F00D, 7'd3);
        wait_quiet();
        write_register(REG_QUEUES_IN_USE, 32'd1);
        send_request(FUNC_POP,  3'd1, '0, 7'd1);
        send_request(FUNC_PUSH, 3'd5, 32'h0000_0042, 7'd2);
        send_request(FUNC_POP,  3'd0, '0, 7'd1);
        wait_quiet();
        write_register(REG_QUEUES_IN_USE, 32'd0);
        send_request(FUNC_PUSH, 3'd0, 32'h0000_0077, 7'd1);
        send_request(FUNC_POP,  3'd0, '0, 7'd1);
        wait_quiet();
        write_register(REG_QUEUES_IN_USE, 32'd15);
        send_request(FUNC_POP,  3'd7, '0, 7'd1);
        send_request(FUNC_POP,  3'd0, '0, 7'd5);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       setting = QUEUES_RESET;
                1:       setting = 4'd3;
                2:       setting = 4'd15;
                3:       setting = 4'd1;
                4:       setting = 4'd6;
                default: setting = CFG_W'($urandom_range(2, 15));
            endcase
            wait_quiet();
            write_register(REG_QUEUES_IN_USE, APB_DATA_W'(setting));
            sender_gaps   = (phase != 1);
            receiver_gaps = (phase != 1);
            if (phase == 2) fill_then_stall();
            random_requests(PHASE_ITEMS);
        end
        wait_quiet();

        $display("Ran %0d pushes, %0d pops, %0d clears and %0d ignored requests",
                 pushes, pops, clears, ignored);
        $display("over %0d register writes; checked %0d results: %0d overflows, %0d empty pops.",
                 reg_writes, results_checked, overflows_seen, nulls_seen);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mqfb_pkg.sv
hdl/mqfb_if.sv
hdl/mqfb_store.sv
hdl/mqfb_ctrl.sv
hdl/multi_queue_burst_fifo_bank.sv
hdl/mqfb_checker.sv
bench/multi_queue_burst_fifo_bank_checker.sv
bench/multi_queue_burst_fifo_bank_tb.sv
